// File: src/mrtq_pkg.sv
`timescale 1ns / 1ps

package mrtq_pkg;

   localparam int BYTE_W      = 8;
   localparam int MSG_LEN_W   = 11;
   localparam int DROP_W      = 32;
   localparam int CLEN_W      = 7;
   localparam int MAX_RESULTS = 64;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_TX_DONE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_STATUS = 4'b0010,
      ST_CHECK  = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   typedef struct packed {
      logic                 opcode;
      logic [BYTE_W-1:0]    data_byte;
      logic [MSG_LEN_W-1:0] msg_len;
      logic                 first_byte;
      logic                 link_ready;
      logic                 tx_busy;
   } req_item_type;

   typedef struct packed {
      logic              out_kind;
      logic              accepted;
      logic [DROP_W-1:0] drop_count;
      logic [BYTE_W-1:0] out_byte;
      logic [CLEN_W-1:0] chunk_len;
      logic              last_in_chunk;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input item taken this cycle
      logic load;     // start a chunk
      logic rd_en;    // read next ring byte, advance tail
      logic emit;     // result channel carries a chunk byte
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_event;
      logic is_first;
      logic commit;
      logic drain_go;
      logic last;
   } dp_status_type;

endpackage

// File: src/mrtq_req_if.sv
`timescale 1ns / 1ps

interface mrtq_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  data_byte;
   logic [10:0] msg_len;
   logic        first_byte;
   logic        link_ready;
   logic        tx_busy;

   modport source (
      output valid, opcode, data_byte, msg_len, first_byte, link_ready, tx_busy,
      input  ready
   );
   modport sink (
      input  valid, opcode, data_byte, msg_len, first_byte, link_ready, tx_busy,
      output ready
   );
endinterface

// File: src/mrtq_rsp_if.sv
`timescale 1ns / 1ps

interface mrtq_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic        accepted;
   logic [31:0] drop_count;
   logic [7:0]  out_byte;
   logic [6:0]  chunk_len;
   logic        last_in_chunk;

   modport source (
      output valid, out_kind, accepted, drop_count, out_byte, chunk_len, last_in_chunk,
      input  ready
   );
   modport sink (
      input  valid, out_kind, accepted, drop_count, out_byte, chunk_len, last_in_chunk,
      output ready
   );
endinterface

// File: src/mrtq_ctrl.sv
`timescale 1ns / 1ps

module mrtq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   input  mrtq_pkg::dp_status_type status,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output mrtq_pkg::ctrl_cmd_type cmd
);
   import mrtq_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;   // commit waiting behind a status item

   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.is_event) begin
                  state_in = ST_CHECK;
               end else if (status.is_first) begin
                  state_in = ST_STATUS;
                  pend_in  = status.commit;
               end else if (status.commit) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_STATUS: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = pend_ff ? ST_CHECK : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_CHECK: begin
            if (status.drain_go) begin
               cmd.load  = 1'b1;
               cmd.rd_en = 1'b1;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.emit  = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// File: src/mrtq_dp.sv
`timescale 1ns / 1ps

module mrtq_dp #(
   parameter int RING_SIZE  = 1024,
   parameter int CHUNK_SIZE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mrtq_pkg::req_item_type item,
   input  mrtq_pkg::ctrl_cmd_type cmd,
   output mrtq_pkg::dp_status_type status,
   output mrtq_pkg::rsp_item_type rsp
);
   import mrtq_pkg::*;

   localparam int IDX_W = $clog2(RING_SIZE);
   localparam int PTR_W = IDX_W + 1;
   localparam int CMP_W = (PTR_W > MSG_LEN_W) ? PTR_W : MSG_LEN_W;

   logic [BYTE_W-1:0] ring_mem [RING_SIZE];

   logic [PTR_W-1:0]     commit_head_ff, commit_head_in;
   logic [PTR_W-1:0]     read_tail_ff, read_tail_in;
   logic [PTR_W-1:0]     write_ptr_ff, write_ptr_in;
   logic [MSG_LEN_W-1:0] bytes_rem_ff, bytes_rem_in;
   logic                 accepting_ff, accepting_in;
   logic [DROP_W-1:0]    drop_ff, drop_in;
   logic                 accepted_ff, accepted_in;
   logic                 link_ok_ff, link_ok_in;
   logic                 room_cut_ff, room_cut_in;
   logic [CLEN_W-1:0]    chunk_len_ff, chunk_len_in;
   logic [CLEN_W-1:0]    idx_ff, idx_in;
   logic [BYTE_W-1:0]    rd_data_ff;

   logic [PTR_W-1:0]  used;
   logic [CMP_W-1:0]  free_space;
   logic              admit;
   logic              is_write;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [PTR_W-1:0]  capped;
   logic [CLEN_W-1:0] chunk_n;

   assign used       = commit_head_ff - read_tail_ff;
   assign free_space = CMP_W'(RING_SIZE) - CMP_W'(used);
   assign is_write   = (item.opcode == OP_WRITE);
   assign admit      = item.link_ready && (item.msg_len != '0) &&
                       (CMP_W'(item.msg_len) <= free_space);

   // chunk length: ring fill, chunk limit, and one slot less behind a status item when it would reach MAX_RESULTS
   assign capped  = (used > PTR_W'(CHUNK_SIZE)) ? PTR_W'(CHUNK_SIZE) : used;
   assign chunk_n = (room_cut_ff && (CLEN_W'(capped) == CLEN_W'(MAX_RESULTS)))
                    ? CLEN_W'(MAX_RESULTS - 1) : CLEN_W'(capped);

   assign status.is_event = (item.opcode == OP_TX_DONE);
   assign status.is_first = is_write && item.first_byte;
   assign status.commit   = is_write &&
      ((item.first_byte && admit && (item.msg_len == MSG_LEN_W'(1))) ||
       (!item.first_byte && accepting_ff && (bytes_rem_ff == MSG_LEN_W'(1))));
   assign status.drain_go = link_ok_ff && (used != '0);
   assign status.last     = (idx_ff == chunk_len_ff - CLEN_W'(1));

   always_comb begin
      commit_head_in = commit_head_ff;
      read_tail_in   = read_tail_ff;
      write_ptr_in   = write_ptr_ff;
      bytes_rem_in   = bytes_rem_ff;
      accepting_in   = accepting_ff;
      drop_in        = drop_ff;
      accepted_in    = accepted_ff;
      link_ok_in     = link_ok_ff;
      room_cut_in    = room_cut_ff;
      chunk_len_in   = chunk_len_ff;
      idx_in         = idx_ff;
      mem_we         = 1'b0;
      mem_waddr      = write_ptr_ff[IDX_W-1:0];

      if (cmd.accept) begin
         link_ok_in  = item.link_ready && !item.tx_busy;
         room_cut_in = status.is_first;
         if (status.is_first) begin
            accepting_in = 1'b0;
            bytes_rem_in = '0;
            write_ptr_in = commit_head_ff;
            if (!admit) begin
               if (drop_ff != '1) begin
                  drop_in = drop_ff + DROP_W'(1);
               end
               accepted_in = 1'b0;
            end else begin
               mem_we       = 1'b1;
               mem_waddr    = commit_head_ff[IDX_W-1:0];
               write_ptr_in = commit_head_ff + PTR_W'(1);
               bytes_rem_in = item.msg_len - MSG_LEN_W'(1);
               accepted_in  = 1'b1;
               if (item.msg_len == MSG_LEN_W'(1)) begin
                  commit_head_in = commit_head_ff + PTR_W'(1);
               end else begin
                  accepting_in = 1'b1;
               end
            end
         end else if (is_write && accepting_ff) begin
            mem_we       = 1'b1;
            write_ptr_in = write_ptr_ff + PTR_W'(1);
            bytes_rem_in = bytes_rem_ff - MSG_LEN_W'(1);
            if (bytes_rem_ff == MSG_LEN_W'(1)) begin
               accepting_in   = 1'b0;
               commit_head_in = write_ptr_ff + PTR_W'(1);
            end
         end
      end

      if (cmd.load) begin
         chunk_len_in = chunk_n;
         idx_in       = '0;
      end else if (cmd.rd_en) begin
         idx_in = idx_ff + CLEN_W'(1);
      end
      if (cmd.rd_en) begin
         read_tail_in = read_tail_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= item.data_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[read_tail_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_head_ff <= '0;
         read_tail_ff   <= '0;
         write_ptr_ff   <= '0;
         bytes_rem_ff   <= '0;
         accepting_ff   <= 1'b0;
         drop_ff        <= '0;
         accepted_ff    <= 1'b0;
         link_ok_ff     <= 1'b0;
         room_cut_ff    <= 1'b0;
         chunk_len_ff   <= '0;
         idx_ff         <= '0;
      end else begin
         commit_head_ff <= commit_head_in;
         read_tail_ff   <= read_tail_in;
         write_ptr_ff   <= write_ptr_in;
         bytes_rem_ff   <= bytes_rem_in;
         accepting_ff   <= accepting_in;
         drop_ff        <= drop_in;
         accepted_ff    <= accepted_in;
         link_ok_ff     <= link_ok_in;
         room_cut_ff    <= room_cut_in;
         chunk_len_ff   <= chunk_len_in;
         idx_ff         <= idx_in;
      end
   end

   always_comb begin
      rsp.out_kind      = cmd.emit;
      rsp.accepted      = cmd.emit ? 1'b0 : accepted_ff;
      rsp.drop_count    = drop_ff;
      rsp.out_byte      = cmd.emit ? rd_data_ff : '0;
      rsp.chunk_len     = cmd.emit ? chunk_len_ff : '0;
      rsp.last_in_chunk = cmd.emit && status.last;
   end

endmodule

// File: src/message_ring_tx_queue.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake   | Item
// req_ch  | in  | valid/ready | opcode, data_byte, msg_len, first_byte, link_ready, tx_busy
// rsp_ch  | out | valid/ready | out_kind, accepted, drop_count, out_byte, chunk_len, last_in_chunk
//
// One item at a time. A plain byte or a dropped/stray byte is taken in ST_IDLE; a first
// byte adds a status item, held while rsp stalls. A commit or transmit-complete
// event adds a drain check; if the link is free and the ring holds committed bytes,
// a chunk drains from the registered ring read port at 1 byte per cycle while rsp_ready is high.
// Synchronous reset clears pointers, admission state and the drop counter; ring
// contents are not cleared. rsp_ready low holds the current result item in place.

module message_ring_tx_queue #(
   parameter int RING_SIZE  = 1024,   // power of two, 64 .. 65536
   parameter int CHUNK_SIZE = 64      // 1 .. 64
) (
   input  logic           clock,
   input  logic           reset,
   mrtq_req_if.sink       req_ch,
   mrtq_rsp_if.source     rsp_ch
);
   import mrtq_pkg::*;

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;

   // pack the incoming item for the datapath
   assign req_item.opcode     = req_ch.opcode;
   assign req_item.data_byte  = req_ch.data_byte;
   assign req_item.msg_len    = req_ch.msg_len;
   assign req_item.first_byte = req_ch.first_byte;
   assign req_item.link_ready = req_ch.link_ready;
   assign req_item.tx_busy    = req_ch.tx_busy;

   // sequencer: idle / status / drain check / chunk output
   mrtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // ring memory, pointers, admission check, drop counter
   mrtq_dp #(
      .RING_SIZE  (RING_SIZE),
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .item   (req_item),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_item)
   );

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.out_kind      = rsp_item.out_kind;
   assign rsp_ch.accepted      = rsp_item.accepted;
   assign rsp_ch.drop_count    = rsp_item.drop_count;
   assign rsp_ch.out_byte      = rsp_item.out_byte;
   assign rsp_ch.chunk_len     = rsp_item.chunk_len;
   assign rsp_ch.last_in_chunk = rsp_item.last_in_chunk;

endmodule
